@@ rtl/core/binary_min_heap_queue_assert.svh @@
// Assertion macros shared by the checker of the priority queue.
// Needs nothing else; take it in by `include where assertions are written.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue assertion failed");

`endif

@@ rtl/core/bmhq_pkg.sv @@
// Shared types, constants and helpers for the priority queue.
// No dependencies; every module file imports it.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 7;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]       count_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic   ins;
        logic   ext;
        value_t key;
    } cell_cmd_t;

    // What a cell hands to its right-hand neighbour.
    typedef struct packed {
        logic   less;
        value_t value;
    } cell_link_t;

    function automatic logic value_less(value_t a, value_t b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [DATA_W-1:0] widen(value_t v);
        return DATA_W'($signed(v));
    endfunction

    function automatic value_t narrow(logic [DATA_W-1:0] d);
        return VALUE_WIDTH'($signed(d));
    endfunction

endpackage

@@ rtl/core/bmhq_cell.sv @@
// One slot of the sorted row: holds a value, compares it with the broadcast key.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps

module bmhq_cell import bmhq_pkg::*; (
    input  logic       aclk,
    input  cell_cmd_t  cmd_i,
    input  logic       occupied_i,
    input  cell_link_t prev_i,
    input  value_t     succ_value_i,
    output cell_link_t link_o,
    output value_t     value_next_o
);

    value_t value_reg;
    value_t value_next;
    logic   less;

    // An empty slot counts as larger than any key.
    assign less = !occupied_i || value_less(cmd_i.key, value_reg);

    always_comb begin
        value_next = value_reg;
        if (cmd_i.ins && less) begin
            // take the left neighbour's value if the key is smaller than it too, else take the key
            value_next = prev_i.less ? prev_i.value : cmd_i.key;
        end else if (cmd_i.ext) begin
            value_next = succ_value_i;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link_o.less   = less;
    assign link_o.value  = value_reg;
    assign value_next_o  = value_next;

endmodule

@@ rtl/core/bmhq_chain.sv @@
// Row of CAPACITY cells kept in ascending order; the head holds the minimum.
// Depends on bmhq_pkg and bmhq_cell.
`timescale 1ns / 1ps

module bmhq_chain import bmhq_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd_i,
    input  count_t    count_i,
    output value_t    head_value_o,
    output value_t    head_next_o
);

    cell_link_t link      [CAPACITY];
    cell_link_t prev_link [CAPACITY];
    value_t     succ_val  [CAPACITY];
    value_t     nxt_val   [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            if (i == 0) begin : g_first
                assign prev_link[i] = '0;
            end else begin : g_prev
                assign prev_link[i] = link[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign succ_val[i] = '0;
            end else begin : g_succ
                assign succ_val[i] = link[i+1].value;
            end

            bmhq_cell u_cell (
                .aclk         (aclk),
                .cmd_i        (cmd_i),
                .occupied_i   (count_i > count_t'(i)),
                .prev_i       (prev_link[i]),
                .succ_value_i (succ_val[i]),
                .link_o       (link[i]),
                .value_next_o (nxt_val[i])
            );
        end
    endgenerate

    assign head_value_o = link[0].value;
    assign head_next_o  = nxt_val[0];

endmodule

@@ rtl/core/binary_min_heap_queue.sv @@
// Priority queue of signed words, minimum first, held in a sorted row of cells.
// The result is valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle while results are taken; every cell compares
// and shifts in parallel, so any insert or extract completes in the cycle it is accepted.
// Reset (aresetn low, synchronous): element count zero, no result pending.
`timescale 1ns / 1ps

module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] extracted, [38:32] element_count,
                                   // [70:39] smallest, [71] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic        accept;
    logic        full;
    logic        empty;
    logic        is_insert;
    cell_cmd_t   cmd;
    count_t      count_reg;
    count_t      count_next;
    value_t      head_value;
    value_t      head_next;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] extracted_reg;
    logic [DATA_W-1:0] extracted_next;
    status_t           status_reg;
    status_t           status_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [DATA_W-1:0] smallest_reg;
    logic [DATA_W-1:0] smallest_next;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == count_t'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign is_insert = (s_tuser[0] == OP_INSERT);

    assign cmd.ins = accept && is_insert && !full;
    assign cmd.ext = accept && (s_tuser[0] == OP_EXTRACT) && !empty;
    assign cmd.key = narrow(s_tdata);

    bmhq_chain u_chain (
        .aclk         (aclk),
        .cmd_i        (cmd),
        .count_i      (count_reg),
        .head_value_o (head_value),
        .head_next_o  (head_next)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + count_t'(1);
        end else if (cmd.ext) begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_comb begin
        extracted_next = '0;
        status_next    = ST_OK;
        if (cmd.ext) begin
            extracted_next = widen(head_value);
        end
        if (is_insert && full) begin
            status_next = ST_FULL;
        end else if (!is_insert && empty) begin
            status_next = ST_EMPTY;
        end
        smallest_next = (count_next == '0) ? '0 : widen(head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload; hold while the result waits downstream.
    always_ff @(posedge aclk) begin
        if (accept) begin
            extracted_reg <= extracted_next;
            status_reg    <= status_next;
            out_count_reg <= COUNT_W'(count_next);
            smallest_reg  <= smallest_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, smallest_reg, out_count_reg, extracted_reg};
    assign m_tuser  = status_reg;

endmodule

@@ rtl/core/bmhq_checker.sv @@
// Port-level checks on the priority queue's result channel, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue_assert.svh.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_assert.svh"

module bmhq_checker import bmhq_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic [DATA_W-1:0]  extracted;
    logic [COUNT_W-1:0] out_count;
    logic [DATA_W-1:0]  smallest;

    assign extracted = m_tdata[31:0];
    assign out_count = m_tdata[38:32];
    assign smallest  = m_tdata[70:39];

    `BMHQ_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `BMHQ_ASSERT_NEXT(a_insert_result, aclk, aresetn, s_tvalid && s_tready && (s_tuser[0] == OP_INSERT), m_tvalid && (m_tuser != ST_EMPTY))
    `BMHQ_ASSERT_IMPLIES(a_full_count, aclk, aresetn, m_tvalid && (m_tuser == ST_FULL), out_count == COUNT_W'(CAPACITY))
    `BMHQ_ASSERT_IMPLIES(a_empty_result, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY), (out_count == '0) && (extracted == '0))
    `BMHQ_ASSERT_IMPLIES(a_no_root, aclk, aresetn, m_tvalid && (out_count == '0), smallest == '0)

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
